// ----- rtl/hsbs_pkg.sv -----
`default_nettype none
package hsbs_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_DUPLICATE = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] hash;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [6:0] position;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_CNT,
    S_PROBE,
    S_PWAIT,
    S_CHECK,
    S_CWAIT,
    S_DECIDE,
    S_SHIFT,
    S_SWAIT,
    S_SWRITE,
    S_PUT,
    S_CLEAR,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/hashed_sorted_bucket_set_unit.sv -----
`default_nettype none
// Channel | Direction | Payload                  | Handshake
// in      | input     | hsbs_pkg::in_item_t      | in_valid / in_stall
// out     | output    | hsbs_pkg::out_item_t     | out_valid / out_stall
//
// One item at a time. A lookup computes the bucket, reads its count, makes each search
// probe (at most log2(BUCKET_DEPTH)+1) as a read and a compare, then closes the search,
// checks and decides. An insert or remove also moves entries one at a time (read,
// capture, write back on the single entry port) and then writes the count. Clear writes
// zero to the count of every bucket before presenting its result. Reset runs the same
// clearing pass over the count memory before the first item; a stalled result is held,
// and the next item is taken in the cycle after delivery.
module hashed_sorted_bucket_set_unit #(
  parameter int BUCKETS      = 64,
  parameter int BUCKET_DEPTH = 64
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  hsbs_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output hsbs_pkg::out_item_t  out_item
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int DW = $clog2(BUCKET_DEPTH);
  localparam int CW = $clog2(BUCKET_DEPTH + 1);
  localparam int AW = BW + DW;
  localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  // Rounded-up reciprocal of BUCKETS scaled by 2^(32+BW); exact for every 32-bit hash.
  localparam longint unsigned RECIP =
    ((longint'(1) << (32 + BW)) + longint'(BUCKETS) - longint'(1)) / longint'(BUCKETS);
  localparam logic [32:0] RECIP_M = 33'(RECIP);

  // Entry memory and count memory, one synchronous port each.
  logic [31:0]   entries [BUCKETS*(1 << DW)];
  logic [CW-1:0] counts  [BUCKETS];

  hsbs_pkg::state_t state, state_next;

  logic [1:0]    op;
  logic [31:0]   key;
  logic [31:0]   quo;
  logic [BW-1:0] bkt;
  logic [CW-1:0] cnt;
  logic [CW-1:0] lo, hi, idx;
  logic          found;
  logic [1:0]    status;
  logic [BW-1:0] sweep;
  logic [31:0]   e_rd;
  logic [CW-1:0] c_rd;
  logic [31:0]   mv;

  logic          e_re, e_we, c_we;
  logic [AW-1:0] e_ra, e_wa;
  logic [31:0]   e_wd;
  logic [BW-1:0] c_a;
  logic [CW-1:0] c_wd;
  logic [CW-1:0] mid;

  // Bucket is hash mod BUCKETS. A power of two is a mask; otherwise the quotient comes
  // from a reciprocal multiply at acceptance; the remainder is settled in the next cycle.
  logic [64:0] prod;
  assign prod = 65'(in_item.hash) * 65'(RECIP_M);

  assign mid = lo + ((hi - lo) >> 1);

  always_ff @(posedge clk) begin
    if (e_we) entries[e_wa] <= e_wd;
    if (e_re) e_rd <= entries[e_ra];
  end

  always_ff @(posedge clk) begin
    if (c_we) counts[c_a] <= c_wd;
    c_rd <= counts[c_a];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hsbs_pkg::S_CLEAR;
      sweep <= '0;
      op    <= hsbs_pkg::OP_LOOKUP;
    end else begin
      state <= state_next;
      case (state)
        hsbs_pkg::S_IDLE: begin
          if (in_valid) begin
            op    <= in_item.op;
            key   <= in_item.hash;
            quo   <= 32'(prod >> (32 + BW));
            sweep <= '0;
          end
        end
        hsbs_pkg::S_HASH: begin
          bkt <= POW2 ? BW'(key & 32'(BUCKETS - 1)) : BW'(key - quo * 32'(BUCKETS));
        end
        hsbs_pkg::S_PWAIT: begin
          cnt <= c_rd;
          lo  <= '0;
          hi  <= c_rd;
        end
        hsbs_pkg::S_CWAIT: begin
          if (e_rd < key) lo <= mid + CW'(1);
          else hi <= mid;
        end
        hsbs_pkg::S_CHECK: begin
          found <= 1'b0;
        end
        hsbs_pkg::S_DECIDE: begin
          if (lo < cnt && e_rd == key) found <= 1'b1;
          if (op == hsbs_pkg::OP_INSERT) idx <= cnt;
          else idx <= lo;
        end
        hsbs_pkg::S_SWAIT: mv <= e_rd;
        hsbs_pkg::S_SWRITE: begin
          if (op == hsbs_pkg::OP_INSERT) idx <= idx - CW'(1);
          else idx <= idx + CW'(1);
        end
        hsbs_pkg::S_CLEAR: sweep <= sweep + BW'(1);
        default: ;
      endcase
    end
  end

  // Status is settled on leaving the search.
  always_ff @(posedge clk) begin
    if (state == hsbs_pkg::S_DECIDE) begin
      status <= hsbs_pkg::ST_OK;
      if (op == hsbs_pkg::OP_INSERT) begin
        if (lo < cnt && e_rd == key) status <= hsbs_pkg::ST_DUPLICATE;
        else if (cnt >= CW'(BUCKET_DEPTH)) status <= hsbs_pkg::ST_FULL;
      end else if (op == hsbs_pkg::OP_REMOVE) begin
        if (!(lo < cnt && e_rd == key)) status <= hsbs_pkg::ST_NOT_FOUND;
      end
    end
  end

  logic do_write;
  assign do_write = (status == hsbs_pkg::ST_OK) &&
                    (op == hsbs_pkg::OP_INSERT || op == hsbs_pkg::OP_REMOVE);

  always_comb begin
    state_next = state;
    case (state)
      hsbs_pkg::S_IDLE:
        if (in_valid) state_next = (in_item.op == hsbs_pkg::OP_CLEAR) ?
                                   hsbs_pkg::S_CLEAR : hsbs_pkg::S_HASH;
      hsbs_pkg::S_HASH:  state_next = hsbs_pkg::S_CNT;
      hsbs_pkg::S_CNT:   state_next = hsbs_pkg::S_PWAIT;
      hsbs_pkg::S_PWAIT: state_next = hsbs_pkg::S_PROBE;
      hsbs_pkg::S_PROBE:
        state_next = (lo < hi) ? hsbs_pkg::S_CWAIT : hsbs_pkg::S_CHECK;
      hsbs_pkg::S_CWAIT: state_next = hsbs_pkg::S_PROBE;
      hsbs_pkg::S_CHECK: state_next = hsbs_pkg::S_DECIDE;
      hsbs_pkg::S_DECIDE: state_next = hsbs_pkg::S_SHIFT;
      hsbs_pkg::S_SHIFT: begin
        if (!do_write) state_next = hsbs_pkg::S_OUT;
        else if (op == hsbs_pkg::OP_INSERT)
          state_next = (idx > lo) ? hsbs_pkg::S_SWAIT : hsbs_pkg::S_PUT;
        else
          state_next = (idx + CW'(1) < cnt) ? hsbs_pkg::S_SWAIT : hsbs_pkg::S_PUT;
      end
      hsbs_pkg::S_SWAIT:  state_next = hsbs_pkg::S_SWRITE;
      hsbs_pkg::S_SWRITE: state_next = hsbs_pkg::S_SHIFT;
      hsbs_pkg::S_PUT:    state_next = hsbs_pkg::S_OUT;
      hsbs_pkg::S_CLEAR:
        if (sweep == BW'(BUCKETS - 1))
          state_next = (op == hsbs_pkg::OP_CLEAR) ? hsbs_pkg::S_OUT : hsbs_pkg::S_IDLE;
      hsbs_pkg::S_OUT: if (!out_stall) state_next = hsbs_pkg::S_IDLE;
      default: state_next = hsbs_pkg::S_IDLE;
    endcase
  end

  // The reset sweep runs with op at a lookup so that it ends in idle with no result.
  logic boot;
  always_ff @(posedge clk) begin
    if (rst) boot <= 1'b1;
    else if (state == hsbs_pkg::S_IDLE) boot <= 1'b0;
  end

  always_comb begin
    e_re = 1'b0; e_we = 1'b0; c_we = 1'b0;
    e_ra = {bkt, mid[DW-1:0]};
    e_wa = {bkt, idx[DW-1:0]};
    e_wd = mv;
    c_a  = bkt;
    c_wd = '0;
    in_stall  = (state != hsbs_pkg::S_IDLE);
    out_valid = (state == hsbs_pkg::S_OUT);
    case (state)
      hsbs_pkg::S_PROBE: e_re = (lo < hi);
      hsbs_pkg::S_CHECK: begin
        e_re = 1'b1;
        e_ra = {bkt, lo[DW-1:0]};
      end
      hsbs_pkg::S_SHIFT: begin
        e_re = 1'b1;
        if (op == hsbs_pkg::OP_INSERT) e_ra = {bkt, DW'(idx - CW'(1))};
        else e_ra = {bkt, DW'(idx + CW'(1))};
      end
      hsbs_pkg::S_SWRITE: e_we = 1'b1;
      hsbs_pkg::S_PUT: begin
        c_we = 1'b1;
        if (op == hsbs_pkg::OP_INSERT) begin
          e_we = 1'b1;
          e_wa = {bkt, lo[DW-1:0]};
          e_wd = key;
          c_wd = cnt + CW'(1);
        end else begin
          c_wd = cnt - CW'(1);
        end
      end
      hsbs_pkg::S_CLEAR: begin
        c_we = 1'b1;
        c_a  = sweep;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_item = '0;
    if (op != hsbs_pkg::OP_CLEAR) begin
      out_item.found    = found;
      out_item.position = 7'(lo);
      out_item.status   = status;
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall)) else $error("input open while result pending");
  a_boot: assert property (@(posedge clk) disable iff (rst)
    boot |-> !out_valid) else $error("result during reset sweep");
  a_bound: assert property (@(posedge clk) disable iff (rst)
    (state == hsbs_pkg::S_DECIDE) |-> (lo <= cnt && cnt <= CW'(BUCKET_DEPTH)))
    else $error("search out of bucket");

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none
module tb;
  import hsbs_pkg::*;

  localparam int NBUCKETS = 64;
  localparam int DEPTH    = 64;
  // The watchdog allows for the clearing pass after reset and the slowest item.
  // The slowest item is a shift of a full bucket plus the longest receiver stall.
  localparam int WATCHDOG_LIMIT = 20000;

  // The scoreboard mirrors the bucket set and queues one expected result per item.
  class bucket_set_scoreboard;
    logic [31:0] entries [NBUCKETS][DEPTH];
    int          counts [NBUCKETS];
    out_item_t   pending_results [$];
    int          errors;

    function new();
      foreach (counts[i]) counts[i] = 0;
      errors = 0;
    endfunction

    // Apply one accepted item to the mirror and queue the result it causes.
    function void note_item(in_item_t item);
      int        b, cnt, lo, hi, mid, pos;
      bit        hit;
      out_item_t res;
      b   = item.hash % NBUCKETS;
      cnt = counts[b];
      res = '0;
      if (item.op == OP_CLEAR) begin
        foreach (counts[i]) counts[i] = 0;
        pending_results.push_back(res);
        return;
      end
      // Binary search for the first entry that is not below the hash.
      lo = 0;
      hi = cnt;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (entries[b][mid] < item.hash) lo = mid + 1;
        else hi = mid;
      end
      pos = lo;
      hit = (pos < cnt) && (entries[b][pos] == item.hash);
      res.found    = hit;
      res.position = pos[6:0];
      res.status   = ST_OK;
      if (item.op == OP_INSERT) begin
        if (hit) res.status = ST_DUPLICATE;
        else if (cnt >= DEPTH) res.status = ST_FULL;
        else begin
          for (int i = cnt; i > pos; i--) entries[b][i] = entries[b][i-1];
          entries[b][pos] = item.hash;
          counts[b] = cnt + 1;
        end
      end else if (item.op == OP_REMOVE) begin
        if (!hit) res.status = ST_NOT_FOUND;
        else begin
          for (int i = pos; i + 1 < cnt; i++) entries[b][i] = entries[b][i+1];
          counts[b] = cnt - 1;
        end
      end
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    // Compare one delivered result with the oldest expectation, field by field.
    task check_result(out_item_t res);
      out_item_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", int'(res), 0);
        return;
      end
      want = pending_results.pop_front();
      if (res.found !== want.found) report_mismatch("found", res.found, want.found);
      if (res.position !== want.position)
        report_mismatch("position", res.position, want.position);
      if (res.status !== want.status) report_mismatch("status", res.status, want.status);
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  bucket_set_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  quiet_cycles  = 0;
  // A small pool of hashes in a few buckets keeps inserts, removes and
  // duplicates hitting the same sorted lists, so buckets fill and drain.
  logic [31:0] hash_pool [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hashed_sorted_bucket_set_unit #(.BUCKETS(NBUCKETS), .BUCKET_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  // Results are sampled on the edge where the handshake completes; the
  // receiver then picks its stall for the next cycle at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Present one item and hold it until accepted, with a random gap first.
  // Valid stays high after acceptance so that items can follow back to back;
  // a gap or wait_drained drops it.
  task automatic send_item(op_t op, logic [31:0] hash);
    in_item_t item;
    item.op   = op;
    item.hash = hash;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(item);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_hash();
    int r;
    r = $urandom_range(99);
    if (r < 70 && hash_pool.size() != 0) return hash_pool[$urandom_range(hash_pool.size() - 1)];
    if (r < 90) return $urandom();
    // Land in one of four hot buckets with random upper bits.
    return {$urandom() & 32'hFFFF_FFC0} | $urandom_range(3);
  endfunction

  function automatic op_t pick_op();
    int r;
    r = $urandom_range(199);
    if (r < 90) return OP_INSERT;
    if (r < 140) return OP_LOOKUP;
    if (r < 198) return OP_REMOVE;
    return OP_CLEAR;
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed items: hash extremes, every operation and every status.
    send_item(OP_LOOKUP, 32'h0000_0000);
    send_item(OP_REMOVE, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h0000_003F);
    send_item(OP_INSERT, 32'h8000_003F);
    send_item(OP_LOOKUP, 32'h4000_003F);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF);
    send_item(OP_REMOVE, 32'h0000_003F);
    send_item(OP_REMOVE, 32'h0000_003F);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_CLEAR,  32'h1234_5678);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF);
    // Fill bucket 5 to the brim in descending order, then overflow it.
    for (int i = DEPTH; i >= 0; i--) send_item(OP_INSERT, (i << 6) | 5);
    send_item(OP_INSERT, 32'hFFFF_FFC5);
    send_item(OP_LOOKUP, 32'hFFFF_FFC5);
    send_item(OP_REMOVE, 32'h0000_0005);
    send_item(OP_CLEAR,  32'hAAAA_AAAA);

    for (int i = 0; i < 40; i++)
      hash_pool.push_back({$urandom() & 32'hFFFF_FFC0} | $urandom_range(3));

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 46 : 0;
      recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 32 : 0;
      for (int i = 0; i < 140; i++) begin
        send_item(pick_op(), pick_hash());
        // Hold off until the block has delivered everything outstanding.
        if (i == 80) wait_drained();
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
